// ----- hw/rtl/ffba_pkg.sv -----
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

  localparam int unsigned HeapBytesDef  = 4096;
  localparam int unsigned AlignBytesDef = 16;

  localparam int unsigned SizeW   = 13;   // size_bytes field
  localparam int unsigned OffW    = 12;   // payload_offset field
  localparam int unsigned CfgW    = 9;    // min_split_bytes register
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [CfgW-1:0] MinSplitRst = CfgW'(32);
  localparam logic [CfgW-1:0] MinBlock    = CfgW'(16);

  // Heap layout constants in bytes
  localparam int unsigned PrologueOff = 0;
  localparam int unsigned TagBytes    = 8;
  localparam int unsigned FirstBlock  = 16;
  localparam int unsigned TagOverhead = 16;
  localparam int unsigned FmtReserve  = 24;
  localparam int unsigned FmtMinSize  = 40;
  localparam int unsigned PrologueTag = 17;  // 16 bytes, allocated
  localparam int unsigned EpilogueTag = 1;   // zero size, allocated

  typedef enum logic {
    CMD_FORMAT = 1'b0,
    CMD_ALLOC  = 1'b1
  } ffba_cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FMT_W0,
    ST_FMT_W1,
    ST_FMT_W2,
    ST_FMT_W3,
    ST_FMT_W4,
    ST_RD,
    ST_WAIT,
    ST_CHECK,
    ST_SPL_W0,
    ST_SPL_W1,
    ST_SPL_W2,
    ST_SPL_W3,
    ST_WHL_W0,
    ST_WHL_W1,
    ST_DONE
  } ffba_state_e;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_PRO_HDR,
    WR_PRO_FTR,
    WR_FREE_HDR,
    WR_FREE_FTR,
    WR_EPI,
    WR_SPL_HDR,
    WR_SPL_FTR,
    WR_REM_HDR,
    WR_REM_FTR,
    WR_WHL_HDR,
    WR_WHL_FTR
  } ffba_wsel_e;

  typedef struct packed {
    logic       load;
    logic       fmt_clear;
    logic       fmt_commit;
    logic       mem_rd;
    logic       latch_tag;
    logic       advance;
    ffba_wsel_e wsel;
    logic       res_set;
    logic       res_ok;
    logic       res_off;
  } ffba_ctl_t;

  typedef struct packed {
    logic is_alloc;
    logic fmt_good;
    logic formatted;
    logic walk_ok;
    logic tag_zero;
    logic fits;
    logic split;
  } ffba_stat_t;

endpackage

// ----- hw/rtl/ffba_datapath.sv -----
// Datapath: tag store, walk pointer, size arithmetic and result registers.
module ffba_datapath #(
  parameter int unsigned HEAP_BYTES  = ffba_pkg::HeapBytesDef,
  parameter int unsigned ALIGN_BYTES = ffba_pkg::AlignBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [ffba_pkg::CfgW-1:0] cfg_data_i,
  input  ffba_pkg::ffba_cmd_e       in_cmd_i,
  input  logic [ffba_pkg::SizeW-1:0] in_size_i,
  input  ffba_pkg::ffba_ctl_t       ctl_i,
  output ffba_pkg::ffba_stat_t      stat_o,
  output logic                      res_ok_o,
  output logic [ffba_pkg::OffW-1:0] res_off_o
);
  import ffba_pkg::*;

  localparam int unsigned TagWords = HEAP_BYTES / TagBytes;
  localparam int unsigned IW = $clog2(TagWords);
  localparam int unsigned BW = $clog2(HEAP_BYTES + 1) + 1;  // tag word width
  localparam int unsigned CW = ((BW > SizeW + 2) ? BW : SizeW + 2) + 1;
  // ALIGN_BYTES is taken as a power of two
  localparam logic [CW-1:0] AlignMask = ~CW'(ALIGN_BYTES - 1);

  logic [BW-1:0]    mem [TagWords];

  ffba_cmd_e        cmd_q;
  logic [SizeW-1:0] sz_q;
  logic [CW-1:0]    bp_q, need_q, size_q, rest_q;
  logic [BW-1:0]    rdata_q;
  logic             rd_oor_q;
  logic             formatted_q;
  logic [SizeW-1:0] heap_limit_q;
  logic [CfgW-1:0]  min_split_q;
  logic             res_ok_q;
  logic [OffW-1:0]  res_off_q;

  logic [CW-1:0]    sz_ext, fsz, need_d, tag_val, tag_size, lim;
  logic [CW-1:0]    waddr, wdata;
  logic             we;

  assign sz_ext = CW'(sz_q);
  assign fsz    = (sz_ext - CW'(FmtReserve)) & AlignMask;
  assign need_d = ((CW'(in_size_i) + CW'(ALIGN_BYTES - 1)) & AlignMask) + CW'(TagOverhead);

  assign tag_val  = rd_oor_q ? '0 : CW'(rdata_q);
  assign tag_size = {tag_val[CW-1:1], 1'b0};
  assign lim      = (min_split_q < MinBlock) ? CW'(MinBlock) : CW'(min_split_q);

  always_comb begin
    stat_o.is_alloc  = (cmd_q == CMD_ALLOC);
    stat_o.fmt_good  = (sz_ext <= CW'(HEAP_BYTES)) && (sz_ext >= CW'(FmtMinSize))
                       && (fsz >= CW'(MinBlock));
    stat_o.formatted = formatted_q;
    stat_o.walk_ok   = (bp_q + CW'(TagBytes)) <= CW'(heap_limit_q);
    stat_o.tag_zero  = (tag_size == '0);
    stat_o.fits      = !tag_val[0] && (tag_size >= need_q);
    stat_o.split     = (rest_q >= lim);
  end

  always_comb begin
    we    = 1'b1;
    waddr = '0;
    wdata = '0;
    case (ctl_i.wsel)
      WR_PRO_HDR: begin
        waddr = CW'(PrologueOff);
        wdata = CW'(PrologueTag);
      end
      WR_PRO_FTR: begin
        waddr = CW'(TagBytes);
        wdata = CW'(PrologueTag);
      end
      WR_FREE_HDR: begin
        waddr = CW'(FirstBlock);
        wdata = fsz;
      end
      WR_FREE_FTR: begin
        waddr = CW'(FirstBlock) + fsz - CW'(TagBytes);
        wdata = fsz;
      end
      WR_EPI: begin
        waddr = CW'(FirstBlock) + fsz;
        wdata = CW'(EpilogueTag);
      end
      WR_SPL_HDR: begin
        waddr = bp_q;
        wdata = need_q | CW'(1);
      end
      WR_SPL_FTR: begin
        waddr = bp_q + need_q - CW'(TagBytes);
        wdata = need_q | CW'(1);
      end
      WR_REM_HDR: begin
        waddr = bp_q + need_q;
        wdata = rest_q;
      end
      WR_REM_FTR: begin
        waddr = bp_q + size_q - CW'(TagBytes);
        wdata = rest_q;
      end
      WR_WHL_HDR: begin
        waddr = bp_q;
        wdata = size_q | CW'(1);
      end
      WR_WHL_FTR: begin
        waddr = bp_q + size_q - CW'(TagBytes);
        wdata = size_q | CW'(1);
      end
      default: we = 1'b0;
    endcase
  end

  // Tag store: one write and one registered read per cycle; drop out-of-range writes
  always_ff @(posedge clk_i) begin
    if (we && ((waddr >> 3) < CW'(TagWords))) begin
      mem[waddr[IW+2:3]] <= wdata[BW-1:0];
    end
    if (ctl_i.mem_rd) begin
      rdata_q <= mem[bp_q[IW+2:3]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= in_cmd_i;
      sz_q   <= in_size_i;
      need_q <= need_d;
      bp_q   <= CW'(FirstBlock);
    end else if (ctl_i.advance) begin
      bp_q <= bp_q + tag_size;
    end
    if (ctl_i.mem_rd) begin
      rd_oor_q <= (bp_q >> 3) >= CW'(TagWords);
    end
    if (ctl_i.latch_tag) begin
      size_q <= tag_size;
      rest_q <= tag_size - need_q;
    end
    if (ctl_i.res_set) begin
      res_ok_q  <= ctl_i.res_ok;
      res_off_q <= ctl_i.res_off ? OffW'(bp_q + CW'(TagBytes)) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      formatted_q  <= 1'b0;
      heap_limit_q <= '0;
      min_split_q  <= MinSplitRst;
    end else begin
      if (cfg_valid_i) begin
        min_split_q <= cfg_data_i;
      end
      if (ctl_i.fmt_clear) begin
        formatted_q  <= 1'b0;
        heap_limit_q <= '0;
      end else if (ctl_i.fmt_commit) begin
        formatted_q  <= 1'b1;
        heap_limit_q <= sz_q;
      end
    end
  end

  assign res_ok_o  = res_ok_q;
  assign res_off_o = res_off_q;

`ifndef SYNTHESIS
  a_rd_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.mem_rd |-> stat_o.walk_ok)
    else $error("tag read beyond heap limit");
  a_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fmt_commit && !ctl_i.fmt_clear |=> formatted_q && heap_limit_q == $past(sz_q))
    else $error("format commit lost");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fmt_clear |=> !formatted_q && heap_limit_q == '0)
    else $error("format clear lost");
`endif

endmodule

// ----- hw/rtl/ffba_ctrl.sv -----
// Controller: sequences format writes, the tag walk and the block update.
module ffba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic                 out_free_i,
  output logic                 push_o,
  input  ffba_pkg::ffba_stat_t stat_i,
  output ffba_pkg::ffba_ctl_t  ctl_o
);
  import ffba_pkg::*;

  ffba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    push_o    = 1'b0;
    ctl_o     = '0;
    ctl_o.wsel = WR_NONE;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!stat_i.is_alloc) begin
          ctl_o.fmt_clear = 1'b1;
          if (stat_i.fmt_good) begin
            state_d = ST_FMT_W0;
          end else begin
            ctl_o.res_set = 1'b1;
            state_d       = ST_DONE;
          end
        end else if (!stat_i.formatted) begin
          ctl_o.res_set = 1'b1;
          state_d       = ST_DONE;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_FMT_W0: begin
        ctl_o.wsel = WR_PRO_HDR;
        state_d    = ST_FMT_W1;
      end
      ST_FMT_W1: begin
        ctl_o.wsel = WR_PRO_FTR;
        state_d    = ST_FMT_W2;
      end
      ST_FMT_W2: begin
        ctl_o.wsel = WR_FREE_HDR;
        state_d    = ST_FMT_W3;
      end
      ST_FMT_W3: begin
        ctl_o.wsel = WR_FREE_FTR;
        state_d    = ST_FMT_W4;
      end
      ST_FMT_W4: begin
        ctl_o.wsel       = WR_EPI;
        ctl_o.fmt_commit = 1'b1;
        ctl_o.res_set    = 1'b1;
        ctl_o.res_ok     = 1'b1;
        state_d          = ST_DONE;
      end
      ST_RD: begin
        if (stat_i.walk_ok) begin
          ctl_o.mem_rd = 1'b1;
          state_d      = ST_WAIT;
        end else begin
          ctl_o.res_set = 1'b1;
          state_d       = ST_DONE;
        end
      end
      ST_WAIT: begin
        // stop at the epilogue, take the first free fit, else hop to the next block
        if (stat_i.tag_zero) begin
          ctl_o.res_set = 1'b1;
          state_d       = ST_DONE;
        end else if (stat_i.fits) begin
          ctl_o.latch_tag = 1'b1;
          state_d         = ST_CHECK;
        end else begin
          ctl_o.advance = 1'b1;
          state_d       = ST_RD;
        end
      end
      ST_CHECK: begin
        state_d = stat_i.split ? ST_SPL_W0 : ST_WHL_W0;
      end
      ST_SPL_W0: begin
        ctl_o.wsel = WR_SPL_HDR;
        state_d    = ST_SPL_W1;
      end
      ST_SPL_W1: begin
        ctl_o.wsel = WR_SPL_FTR;
        state_d    = ST_SPL_W2;
      end
      ST_SPL_W2: begin
        ctl_o.wsel = WR_REM_HDR;
        state_d    = ST_SPL_W3;
      end
      ST_SPL_W3: begin
        ctl_o.wsel    = WR_REM_FTR;
        ctl_o.res_set = 1'b1;
        ctl_o.res_ok  = 1'b1;
        ctl_o.res_off = 1'b1;
        state_d       = ST_DONE;
      end
      ST_WHL_W0: begin
        ctl_o.wsel = WR_WHL_HDR;
        state_d    = ST_WHL_W1;
      end
      ST_WHL_W1: begin
        ctl_o.wsel    = WR_WHL_FTR;
        ctl_o.res_set = 1'b1;
        ctl_o.res_ok  = 1'b1;
        ctl_o.res_off = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the beat
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_i && s_ready_o |=> state_q == ST_DECODE)
    else $error("accepted beat not decoded");
  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> state_q == ST_IDLE && s_ready_o)
    else $error("controller not idle after result push");
  a_check_after_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> $past(state_q) == ST_WAIT && $past(stat_i.fits))
    else $error("split check without a fitting block");
`endif

endmodule

// ----- hw/rtl/first_fit_block_allocator.sv -----
// Top level: first-fit allocator over a boundary-tagged heap.
//
// Input channel s_axis: tuser[0] is the command (0 format, 1 allocate),
// tdata[12:0] the size in bytes. Output channel m_axis: tuser[0] is ok,
// tdata[11:0] the payload offset (0 on failure or format).
// cfg_valid_i/cfg_data_i write min_split_bytes; the port is always ready.
// Write it only while no item is in flight.
// One item is worked at a time; s_axis_tready_o is high only when idle.
// Format: a good size gives 5 tag writes; a bad size fails with no write.
// Allocate: after decode, each block header visited takes a tag read and then
// the decision on the registered read data; a fit is taken whole, or split into
// the taken block and a tagged remainder; a walk fails at epilogue or heap limit.
// The single read port of the tag store sets the walk rate.
// The result sits in an output register; while the receiver stalls the
// block holds one finished result there, and a second finished result waits
// in the controller until the register frees up.
// Reset clears the formatted flag, the heap limit and the controller;
// min_split_bytes returns to 32. The tag store is not cleared.
module first_fit_block_allocator #(
  parameter int unsigned HEAP_BYTES  = ffba_pkg::HeapBytesDef,
  parameter int unsigned ALIGN_BYTES = ffba_pkg::AlignBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ffba_pkg::InDataW-1:0]  s_axis_tdata_i,   // [12:0] size_bytes
  input  logic [0:0]                    s_axis_tuser_i,   // [0] command
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [ffba_pkg::OutDataW-1:0] m_axis_tdata_o,   // [11:0] payload_offset
  output logic [0:0]                    m_axis_tuser_o,   // [0] ok
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffba_pkg::CfgW-1:0]     cfg_data_i
);
  import ffba_pkg::*;

  ffba_ctl_t       ctl;
  ffba_stat_t      stat;
  logic            push, out_free;
  logic            res_ok;
  logic [OffW-1:0] res_off;
  logic            m_valid_q;
  logic            m_ok_q;
  logic [OffW-1:0] m_off_q;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !m_valid_q || m_axis_tready_i;

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .out_free_i (out_free),
    .push_o     (push),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  ffba_datapath #(
    .HEAP_BYTES  (HEAP_BYTES),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_cmd_i    (ffba_cmd_e'(s_axis_tuser_i[0])),
    .in_size_i   (s_axis_tdata_i[SizeW-1:0]),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .res_ok_o    (res_ok),
    .res_off_o   (res_off)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (push) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      m_ok_q  <= res_ok;
      m_off_q <= res_off;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_ok_q;
  assign m_axis_tdata_o  = {{(OutDataW - OffW){1'b0}}, m_off_q};

endmodule

// ----- verif/tb_first_fit_block_allocator.sv -----
// Self-checking testbench for the first-fit block allocator: directed table, then random heaps.
`timescale 1ns / 100ps

module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  localparam int unsigned HeapSize   = 4096;
  localparam int unsigned Align      = 16;
  localparam int unsigned TagCount   = HeapSize / 8;
  localparam int unsigned SegCount   = 9;
  localparam int unsigned SegItems   = 40;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic        ok;
    logic [11:0] offset;
  } grant_t;

  typedef struct packed {
    ffba_cmd_e   cmd;
    logic [12:0] size;
    logic        known;
    logic        ok;
    logic [11:0] offset;
  } dir_row_t;

  // known = 1: expected grant typed in; otherwise taken from the predictor
  localparam dir_row_t DirTable [25] = '{
    '{CMD_ALLOC,  13'd16,   1'b1, 1'b0, 12'd0},   // allocate before any format
    '{CMD_FORMAT, 13'd0,    1'b1, 1'b0, 12'd0},
    '{CMD_FORMAT, 13'd39,   1'b1, 1'b0, 12'd0},
    '{CMD_FORMAT, 13'd8191, 1'b1, 1'b0, 12'd0},
    '{CMD_FORMAT, 13'd4097, 1'b1, 1'b0, 12'd0},
    '{CMD_ALLOC,  13'd0,    1'b1, 1'b0, 12'd0},   // still unformatted
    '{CMD_FORMAT, 13'd40,   1'b1, 1'b1, 12'd0},   // smallest heap
    '{CMD_ALLOC,  13'd0,    1'b1, 1'b1, 12'd24},
    '{CMD_ALLOC,  13'd0,    1'b1, 1'b0, 12'd0},   // heap full
    '{CMD_FORMAT, 13'd4096, 1'b1, 1'b1, 12'd0},
    '{CMD_ALLOC,  13'd8191, 1'b1, 1'b0, 12'd0},
    '{CMD_ALLOC,  13'd4048, 1'b1, 1'b1, 12'd24},  // exact fit, no split
    '{CMD_ALLOC,  13'd1,    1'b1, 1'b0, 12'd0},
    '{CMD_FORMAT, 13'd4096, 1'b1, 1'b1, 12'd0},   // reformat drops the layout
    '{CMD_ALLOC,  13'd1,    1'b1, 1'b1, 12'd24},
    '{CMD_ALLOC,  13'd17,   1'b0, 1'b0, 12'd0},
    '{CMD_ALLOC,  13'd4000, 1'b0, 1'b0, 12'd0},
    '{CMD_ALLOC,  13'd3952, 1'b0, 1'b0, 12'd0},
    '{CMD_ALLOC,  13'd0,    1'b0, 1'b0, 12'd0},
    '{CMD_FORMAT, 13'd100,  1'b1, 1'b1, 12'd0},
    '{CMD_ALLOC,  13'd15,   1'b0, 1'b0, 12'd0},
    '{CMD_ALLOC,  13'd0,    1'b0, 1'b0, 12'd0},
    '{CMD_ALLOC,  13'd0,    1'b0, 1'b0, 12'd0},
    '{CMD_FORMAT, 13'd4095, 1'b1, 1'b1, 12'd0},
    '{CMD_ALLOC,  13'd4096, 1'b0, 1'b0, 12'd0}
  };

  localparam logic [8:0] FloorPlan [SegCount] = '{
    9'd16, 9'd256, 9'd0, 9'd511, 9'd32, 9'd48, 9'd170, 9'd341, 9'd255
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [0:0]          s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [0:0]          m_axis_tuser_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i = '0;

  // Predictor state
  bit [13:0]   tag_words [TagCount];
  int unsigned heap_top = 0;
  bit          heap_ready = 1'b0;
  bit [8:0]    split_floor = 9'd32;

  grant_t      grant_queue [$];
  int unsigned fail_count = 0;
  int unsigned feed_idle_pct = 27;
  int unsigned sink_idle_pct = 66;
  int unsigned holdoff_asked = 0;

  first_fit_block_allocator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [12:0] size_bytes
    .s_axis_tuser_i  (s_axis_tuser_i),   // [0] command
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [11:0] payload_offset
    .m_axis_tuser_o  (m_axis_tuser_o),   // [0] ok
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  function automatic void put_tag(int unsigned addr, int unsigned value);
    if ((addr >> 3) < TagCount) tag_words[addr >> 3] = 14'(value);
  endfunction

  function automatic grant_t predict_grant(ffba_cmd_e cmd, logic [12:0] size);
    grant_t      g;
    int unsigned req, fsz, need, floor_b, bp, tag, blk, rest;
    bit          done;
    g = '0;
    req = size;
    done = 1'b0;
    if (cmd == CMD_FORMAT) begin
      heap_ready = 1'b0;
      heap_top = 0;
      if (req <= HeapSize && req >= 40) begin
        fsz = req - 24;
        fsz = fsz - (fsz % Align);
        if (fsz >= 16) begin
          put_tag(0, 17);
          put_tag(8, 17);
          put_tag(16, fsz);
          put_tag(16 + fsz - 8, fsz);
          put_tag(16 + fsz, 1);
          heap_top = req;
          heap_ready = 1'b1;
          g.ok = 1'b1;
        end
      end
    end else if (heap_ready) begin
      need = ((req + Align - 1) / Align) * Align + 16;
      floor_b = (split_floor < 16) ? 16 : split_floor;
      bp = 16;
      while (!done && bp + 8 <= heap_top) begin
        tag = tag_words[bp >> 3];
        blk = tag & ~32'd1;
        if (blk == 0) begin
          done = 1'b1;
        end else if ((tag & 1) == 0 && blk >= need) begin
          rest = blk - need;
          if (rest >= floor_b) begin
            put_tag(bp, need | 1);
            put_tag(bp + need - 8, need | 1);
            put_tag(bp + need, rest);
            put_tag(bp + blk - 8, rest);
          end else begin
            put_tag(bp, blk | 1);
            put_tag(bp + blk - 8, blk | 1);
          end
          g.ok = 1'b1;
          g.offset = 12'(bp + 8);
          done = 1'b1;
        end else begin
          bp += blk;
        end
      end
    end
    return g;
  endfunction

  // Offer one item after a random gap; return once it is accepted.
  task automatic send_item(input ffba_cmd_e cmd, input logic [12:0] size,
                           output grant_t grant);
    while ($urandom_range(99) < feed_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, size};
    s_axis_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    grant = predict_grant(cmd, size);
  endtask

  task automatic send_predicted(input ffba_cmd_e cmd, input logic [12:0] size);
    grant_t grant;
    send_item(cmd, size, grant);
    grant_queue.push_back(grant);
  endtask

  // Drop valid and wait until every grant has come back.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (grant_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_split_floor(input logic [8:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    split_floor = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [12:0] pick_alloc_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return 13'($urandom_range(48));
    if (pick < 80) return 13'($urandom_range(256));
    if (pick < 95) return 13'($urandom_range(1024));
    return 13'($urandom_range(8191));
  endfunction

  function automatic logic [12:0] pick_heap_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return 13'($urandom_range(600, 40));
    if (pick < 92) return 13'($urandom_range(4096, 40));
    return 13'(HeapSize);
  endfunction

  initial begin : result_sink
    grant_t      want;
    int unsigned quiet;
    int unsigned holdoff_served;
    quiet = 0;
    holdoff_served = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        if (grant_queue.size() == 0) begin
          $error("unexpected beat: ok %0d payload_offset %0d",
                 m_axis_tuser_o[0], m_axis_tdata_o[11:0]);
          fail_count++;
        end else begin
          want = grant_queue.pop_front();
          if (m_axis_tuser_o[0] !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, m_axis_tuser_o[0]);
            fail_count++;
          end
          if (m_axis_tdata_o[11:0] !== want.offset) begin
            $error("payload_offset: expected %0d, got %0d",
                   want.offset, m_axis_tdata_o[11:0]);
            fail_count++;
          end
        end
      end
      // Hold off for a long stretch when asked, so the block backs up.
      if (quiet > 0) begin
        quiet--;
        m_axis_tready_i <= 1'b0;
      end else if (holdoff_served != holdoff_asked) begin
        holdoff_served++;
        quiet = HoldCycles;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
      if (stuck >= StallLimit) begin
        $error("no beat for %0d cycles", stuck);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    grant_t      grant;
    int unsigned sent, burst, pick, mode;
    logic [8:0]  floor_val;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset split limit
    for (int i = 0; i < 25; i++) begin
      send_item(DirTable[i].cmd, DirTable[i].size, grant);
      if (DirTable[i].known) begin
        grant.ok = DirTable[i].ok;
        grant.offset = DirTable[i].offset;
      end
      grant_queue.push_back(grant);
    end

    // Random part: one split limit per segment, idling pattern per group of three
    for (int seg = 0; seg < SegCount; seg++) begin
      settle();
      mode = seg / 3;
      feed_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 66 : 0;
      sink_idle_pct <= (mode == 0) ? 66 : (mode == 1) ? 27 : 0;
      floor_val = (seg == 4 || seg == 8) ? 9'($urandom_range(511)) : FloorPlan[seg];
      write_split_floor(floor_val);
      if (seg == 2 || seg == 6) holdoff_asked <= holdoff_asked + 1;
      sent = 0;
      while (sent < SegItems) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          // Fresh heap followed by a run of allocations
          send_predicted(CMD_FORMAT, pick_heap_size());
          burst = $urandom_range(20, 3);
        end else if (pick < 92) begin
          if ($urandom_range(1)) send_predicted(CMD_FORMAT, 13'($urandom_range(39)));
          else send_predicted(CMD_FORMAT, 13'($urandom_range(8191, 4097)));
          burst = $urandom_range(3, 1);
        end else begin
          // Keep allocating from whatever heap is there
          burst = $urandom_range(6, 1) - 1;
          send_predicted(CMD_ALLOC, pick_alloc_size());
        end
        sent++;
        for (int k = 0; k < burst; k++) begin
          send_predicted(CMD_ALLOC, pick_alloc_size());
          sent++;
        end
      end
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
